/* rtl/pcs_pkg.sv */
// Shared types, character constants and helper functions of the progressive Caesar cipher.
// No dependencies; used by pcs_cfg, pcs_core and the top level.
package pcs_pkg;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY  = 1'b1;

	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] WIN_DEPTH = 3'd6;
	localparam logic [2:0] MARK_LEN  = 3'd7;

	typedef struct packed {
		logic       mode;
		logic [4:0] letter_base;
		logic [3:0] digit_base;
		logic       restart;
	} cfg_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       hit;
	} xf_t;

	// Signed 16-bit key mod 26 by nibble folding and a reciprocal multiply.
	function automatic logic [4:0] key_mod26(input logic [15:0] k);
		logic [9:0]  x;
		logic [17:0] p;
		logic [4:0]  q;
		logic [9:0]  r;
		x = 10'(k[3:0]) + 10'(k[7:4]) * 10'd16 + 10'(k[11:8]) * 10'd22
			+ 10'(k[15:12]) * 10'd14 + (k[15] ? 10'd10 : 10'd0);
		p = 18'(x) * 18'd315;
		q = p[17:13];
		r = x - 10'(q) * 10'd26;
		if (r >= 10'd26) begin
			r = r - 10'd26;
		end
		return r[4:0];
	endfunction

	// Signed 16-bit key mod 10, same scheme.
	function automatic logic [3:0] key_mod10(input logic [15:0] k);
		logic [8:0]  x;
		logic [17:0] p;
		logic [4:0]  q;
		logic [8:0]  r;
		x = 9'(k[3:0]) + (9'(k[7:4]) + 9'(k[11:8]) + 9'(k[15:12])) * 9'd6
			+ (k[15] ? 9'd4 : 9'd0);
		p = 18'(x) * 18'd819;
		q = p[17:13];
		r = x - 9'(q) * 9'd10;
		if (r >= 9'd10) begin
			r = r - 9'd10;
		end
		return r[3:0];
	endfunction

	function automatic logic [4:0] rot26(input logic [4:0] v, input logic [4:0] sh,
			input logic dec);
		logic [5:0] t;
		t = dec ? (6'(v) + 6'd26 - 6'(sh)) : (6'(v) + 6'(sh));
		if (t >= 6'd26) begin
			t = t - 6'd26;
		end
		return t[4:0];
	endfunction

	function automatic logic [3:0] rot10(input logic [3:0] v, input logic [3:0] sh,
			input logic dec);
		logic [4:0] t;
		t = dec ? (5'(v) + 5'd10 - 5'(sh)) : (5'(v) + 5'(sh));
		if (t >= 5'd10) begin
			t = t - 5'd10;
		end
		return t[3:0];
	endfunction

	function automatic xf_t xform(input logic [7:0] c, input logic dec,
			input logic [4:0] lsh, input logic [3:0] dsh);
		xf_t        r;
		logic [7:0] off;
		r.ch = c;
		r.hit = 1'b1;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			off = c - CH_UP_A;
			r.ch = CH_UP_A + 8'(rot26(off[4:0], lsh, dec));
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			off = c - CH_LO_A;
			r.ch = CH_LO_A + 8'(rot26(off[4:0], lsh, dec));
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			off = c - CH_ZERO;
			r.ch = CH_ZERO + 8'(rot10(off[3:0], dsh, dec));
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [7:0] marker_byte(input logic [2:0] i);
		logic [7:0] b;
		case (i)
			3'd2:    b = CH_E;
			3'd3:    b = CH_O;
			3'd4:    b = CH_M;
			default: b = CH_US;
		endcase
		return b;
	endfunction

endpackage

/* rtl/pcs_cfg.sv */
// Configuration registers of the progressive Caesar cipher: mode and the reduced key shifts.
// Depends on pcs_pkg; feeds pcs_core through a cfg_t struct.
module pcs_cfg
	import pcs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [15:0]               wr_data,
	output cfg_t                      cfg
);

	logic       mode_q;
	logic [4:0] letter_base_q;
	logic [3:0] digit_base_q;
	logic       restart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_ENCRYPT;
			letter_base_q <= 5'd0;
			digit_base_q  <= 4'd0;
			restart_q     <= 1'b0;
		end else begin
			restart_q <= wr_en;
			if (wr_en) begin
				unique case (wr_index)
					REG_MODE: mode_q <= wr_data[0];
					REG_KEY: begin
						letter_base_q <= key_mod26(wr_data);
						digit_base_q  <= key_mod10(wr_data);
					end
					default: ;
				endcase
			end
		end
	end

	assign cfg.mode        = mode_q;
	assign cfg.letter_base = letter_base_q;
	assign cfg.digit_base  = digit_base_q;
	assign cfg.restart     = restart_q;

endmodule

/* rtl/pcs_core.sv */
// Cipher datapath: input register, shift and count state, hold window, marker sequencer
// and result register. Depends on pcs_pkg and takes the cfg_t struct that pcs_cfg drives.
module pcs_core
	import pcs_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        msg_end,
	output logic        status,
	output logic [15:0] char_count
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;

	logic [4:0]            letter_shift_q;
	logic [3:0]            digit_shift_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [7:0]            win_q [6];
	logic [2:0]            fill_q;
	logic                  marker_q;
	logic [2:0]            phase_q;

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  byte_valid_q;
	logic                  msg_end_q;
	logic                  status_q;
	logic [15:0]           char_count_q;

	logic                  out_free;
	logic                  go;
	logic                  full;
	logic                  match;
	logic                  dec_step;
	logic                  dec_found;
	logic                  dec_emit;
	logic                  dec_append;
	logic [7:0]            xsrc;
	xf_t                   xf;
	logic                  do_x;
	logic                  emit;
	logic                  consume;
	logic                  end_msg;
	logic                  restart_all;
	logic [7:0]            e_byte;
	logic                  e_bvalid;
	logic                  e_end;
	logic                  e_status;
	logic [15:0]           e_count;
	logic [COUNT_BITS-1:0] count_nx;
	logic [2:0]            phase_nx;

	assign out_free = !out_valid_q || out_ready;
	assign go       = valid_s1 && out_free && !cfg.restart;
	assign in_ready = !valid_s1 || (go && consume);

	always_comb begin
		full  = (fill_q == WIN_DEPTH);
		match = win_q[0] == CH_US && win_q[1] == CH_US && win_q[2] == CH_E
			&& win_q[3] == CH_O && win_q[4] == CH_M && win_q[5] == CH_US
			&& byte_s1 == CH_US;
		dec_step   = (cfg.mode == MODE_DECRYPT) && (phase_q == 3'd0) && !marker_q;
		dec_found  = dec_step && full && match;
		dec_emit   = dec_step && full && !match;
		dec_append = dec_step && !full;
		xsrc = (cfg.mode == MODE_DECRYPT) ? win_q[0] : byte_s1;
		xf   = xform(xsrc, cfg.mode, letter_shift_q, digit_shift_q);

		do_x     = 1'b0;
		emit     = 1'b0;
		consume  = 1'b0;
		end_msg  = 1'b0;
		e_byte   = 8'd0;
		e_bvalid = 1'b0;
		e_end    = 1'b0;
		e_status = 1'b0;
		e_count  = 16'd0;
		phase_nx = phase_q + 3'd1;

		if (cfg.mode == MODE_ENCRYPT) begin
			if (phase_q == 3'd0) begin
				do_x     = 1'b1;
				emit     = 1'b1;
				e_byte   = xf.ch;
				e_bvalid = 1'b1;
				consume  = !last_s1;
			end else begin
				emit     = 1'b1;
				e_byte   = marker_byte(phase_q - 3'd1);
				e_bvalid = 1'b1;
				if (phase_q == MARK_LEN) begin
					e_end   = 1'b1;
					e_count = 16'(count_q);
					end_msg = 1'b1;
					consume = 1'b1;
				end
			end
		end else begin
			if (phase_q == 3'd0) begin
				do_x = dec_emit;
				if (dec_emit) begin
					emit     = 1'b1;
					e_byte   = xf.ch;
					e_bvalid = 1'b1;
				end
				if (!last_s1) begin
					consume = 1'b1;
				end else if (!dec_emit) begin
					emit     = 1'b1;
					e_end    = 1'b1;
					e_status = !(marker_q || dec_found);
					e_count  = e_status ? 16'd0 : 16'(count_q);
					end_msg  = 1'b1;
					consume  = 1'b1;
				end
			end else begin
				emit     = 1'b1;
				e_end    = 1'b1;
				e_status = !marker_q;
				e_count  = marker_q ? 16'(count_q) : 16'd0;
				end_msg  = 1'b1;
				consume  = 1'b1;
			end
		end

		count_nx = count_q;
		if (do_x && xf.hit && count_q != '1) begin
			count_nx = count_q + COUNT_BITS'(1);
		end
	end

	assign restart_all = cfg.restart || (go && end_msg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_shift_q <= 5'd0;
			digit_shift_q  <= 4'd0;
			count_q        <= '0;
			fill_q         <= 3'd0;
			marker_q       <= 1'b0;
			phase_q        <= 3'd0;
		end else begin
			if (restart_all) begin
				letter_shift_q <= cfg.letter_base;
				digit_shift_q  <= cfg.digit_base;
				count_q        <= '0;
				fill_q         <= 3'd0;
				marker_q       <= 1'b0;
			end else if (go) begin
				if (do_x) begin
					letter_shift_q <= (letter_shift_q == 5'd25) ? 5'd0 : letter_shift_q + 5'd1;
					digit_shift_q  <= (digit_shift_q >= 4'd8) ? digit_shift_q - 4'd8
						: digit_shift_q + 4'd2;
				end
				count_q <= count_nx;
				if (dec_found) begin
					fill_q   <= 3'd0;
					marker_q <= 1'b1;
				end else if (dec_append) begin
					fill_q <= fill_q + 3'd1;
				end
			end
			if (cfg.restart) begin
				phase_q <= 3'd0;
			end else if (go) begin
				phase_q <= consume ? 3'd0 : phase_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && dec_emit) begin
			for (int i = 0; i < 5; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[5] <= byte_s1;
		end else if (go && dec_append) begin
			win_q[fill_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_byte_q   <= e_byte;
			byte_valid_q <= e_bvalid;
			msg_end_q    <= e_end;
			status_q     <= e_status;
			char_count_q <= e_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign msg_end    = msg_end_q;
	assign status     = status_q;
	assign char_count = char_count_q;

endmodule

/* rtl/progressive_caesar_stream_cipher.sv */
// A byte passes through the input register and then the result register; back-pressure on
// the output or a configuration write can hold it in the input register between the two.
// Throughput: one byte per cycle while the output takes results and no configuration write
// is pending; in encrypt mode the last byte holds the input while the seven marker bytes follow,
// and in decrypt mode a last byte that releases a held byte is held once more for the end record.
// Reset clears mode and key to zero and starts a new message; a configuration write also does.
// Top level of the progressive Caesar cipher; depends on pcs_pkg, pcs_cfg and pcs_core.
module progressive_caesar_stream_cipher
	import pcs_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte,
	output logic                      byte_valid,
	output logic                      msg_end,
	output logic                      status,
	output logic [15:0]               char_count
);

	cfg_t cfg;

	assign cfg_ready = 1'b1;

	pcs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pcs_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.msg_end    (msg_end),
		.status     (status),
		.char_count (char_count)
	);

endmodule
